>>> hdl/imuoc_pkg.sv
// shared constants and types for the imu offset calibration moving average core
package imuoc_pkg;

    localparam int AXES        = 6;
    localparam int WINDOW      = 8;
    localparam int CAL_SAMPLES = 64;

    localparam int SAMPLE_W = 16;
    localparam int GRAV_W   = 15;
    localparam int OUT_W    = 19;
    localparam int PTR_W    = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(CAL_SAMPLES + 1);
    localparam int ACC_W    = SAMPLE_W + 1 + $clog2(CAL_SAMPLES);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GRAV_W;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = GRAV_W'(65536 / 16);

    localparam int AXIS_ACC_Z = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY_COUNTS = 2'd0,
        REG_OFFSETS_LOCKED = 2'd1
    } cfg_reg_t;

    // per-beat calibration control from the sequencer
    typedef struct packed {
        logic acc_en;
        logic acc_done;
        logic acc_busy;
        logic gyro_en;
        logic gyro_done;
        logic gyro_busy;
    } cal_ctrl_t;

    // what one lane needs from the sequencer
    typedef struct packed {
        logic en;
        logic done;
    } lane_cal_t;

endpackage

>>> hdl/imuoc_cal_ctrl.sv
// calibration sequencer: active flags and sample counters for both sensor groups
module imuoc_cal_ctrl
    import imuoc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic      start_acc,
    input  logic      start_gyro,
    output cal_ctrl_t ctrl
);

    logic             acc_active_reg;
    logic             gyro_active_reg;
    logic [CNT_W-1:0] acc_cnt_reg;
    logic [CNT_W-1:0] gyro_cnt_reg;
    logic [CNT_W-1:0] acc_cnt_next;
    logic [CNT_W-1:0] gyro_cnt_next;

    // a start while busy just folds into the running collection
    always_comb
    begin
        acc_cnt_next   = acc_cnt_reg + CNT_W'(1);
        gyro_cnt_next  = gyro_cnt_reg + CNT_W'(1);
        ctrl.acc_en    = acc_active_reg | start_acc;
        ctrl.gyro_en   = gyro_active_reg | start_gyro;
        ctrl.acc_done  = ctrl.acc_en & (acc_cnt_next >= CNT_W'(CAL_SAMPLES));
        ctrl.gyro_done = ctrl.gyro_en & (gyro_cnt_next >= CNT_W'(CAL_SAMPLES));
        ctrl.acc_busy  = ctrl.acc_en & ~ctrl.acc_done;
        ctrl.gyro_busy = ctrl.gyro_en & ~ctrl.gyro_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_active_reg  <= 1'b0;
            gyro_active_reg <= 1'b0;
            acc_cnt_reg     <= '0;
            gyro_cnt_reg    <= '0;
        end
        else if (accept)
        begin
            if (ctrl.acc_en)
            begin
                acc_active_reg <= ~ctrl.acc_done;
                acc_cnt_reg    <= ctrl.acc_done ? '0 : acc_cnt_next;
            end
            if (ctrl.gyro_en)
            begin
                gyro_active_reg <= ~ctrl.gyro_done;
                gyro_cnt_reg    <= ctrl.gyro_done ? '0 : gyro_cnt_next;
            end
        end
    end

endmodule

>>> hdl/imuoc_lane.sv
// one axis lane: offset accumulator, learned offset, correction ring and running window sum
module imuoc_lane
    import imuoc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load1,
    input  logic                       load2,
    input  logic                       load3,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  lane_cal_t                  cal,
    input  logic [GRAV_W-1:0]          bias,
    input  logic                       locked,
    input  logic [PTR_W-1:0]           wp,
    output logic signed [OUT_W-1:0]    sum
);

    localparam int EXT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam logic signed [ACC_W-1:0] CAL_DIV = ACC_W'(CAL_SAMPLES);
    localparam logic signed [ACC_W-1:0] OFF_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] OFF_MIN = ACC_W'(-32768);
    localparam logic signed [SAMPLE_W:0] COR_MAX = (SAMPLE_W + 1)'(32767);
    localparam logic signed [SAMPLE_W:0] COR_MIN = (SAMPLE_W + 1)'(-32768);
    localparam logic signed [EXT_W-1:0] SUM_MAX = EXT_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [EXT_W-1:0] SUM_MIN = EXT_W'(-(2 ** (OUT_W - 1)));

    // stage 1: accumulate
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    sample_ext;
    logic signed [ACC_W-1:0]    bias_ext;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic signed [ACC_W-1:0]    s1_acc_reg;
    logic                       s1_done_reg;

    // stage 2: learned offset
    logic signed [ACC_W-1:0]    quot;
    logic signed [SAMPLE_W-1:0] off_new;
    logic signed [SAMPLE_W-1:0] s2_sample_reg;
    logic signed [SAMPLE_W-1:0] s2_off_reg;
    logic                       s2_done_reg;

    // stage 3: correction and window
    logic signed [SAMPLE_W-1:0] off_reg;
    logic signed [SAMPLE_W-1:0] off_use;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W-1:0] corr;
    logic signed [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [EXT_W-1:0]    sum_ext;

    always_comb
    begin
        sample_ext = ACC_W'(sample);
        bias_ext   = signed'({{(ACC_W - GRAV_W){1'b0}}, bias});
        acc_next   = acc_reg + sample_ext - bias_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (load1 && cal.en)
        begin
            acc_reg <= cal.done ? '0 : acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_sample_reg <= sample;
            s1_acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_done_reg <= 1'b0;
            s2_done_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                s1_done_reg <= cal.en & cal.done;
            end
            if (load2)
            begin
                s2_done_reg <= s1_done_reg & ~locked;
            end
        end
    end

    // signed divide truncates toward zero
    always_comb
    begin
        quot = s1_acc_reg / CAL_DIV;
        if (quot > OFF_MAX)
        begin
            off_new = SAMPLE_W'(OFF_MAX);
        end
        else if (quot < OFF_MIN)
        begin
            off_new = SAMPLE_W'(OFF_MIN);
        end
        else
        begin
            off_new = SAMPLE_W'(quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_sample_reg <= s1_sample_reg;
            s2_off_reg    <= off_new;
        end
    end

    // the beat that ends a calibration already uses the new offset
    always_comb
    begin
        off_use = s2_done_reg ? s2_off_reg : off_reg;
        diff    = (SAMPLE_W + 1)'(s2_sample_reg) - (SAMPLE_W + 1)'(off_use);
        if (diff > COR_MAX)
        begin
            corr = SAMPLE_W'(COR_MAX);
        end
        else if (diff < COR_MIN)
        begin
            corr = SAMPLE_W'(COR_MIN);
        end
        else
        begin
            corr = SAMPLE_W'(diff);
        end
        sum_next = sum_reg + SUM_W'(corr) - SUM_W'(ring_reg[wp]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            sum_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (load3)
        begin
            if (s2_done_reg)
            begin
                off_reg <= s2_off_reg;
            end
            ring_reg[wp] <= corr;
            sum_reg      <= sum_next;
        end
    end

    always_comb
    begin
        sum_ext = EXT_W'(sum_reg);
        if (sum_ext > SUM_MAX)
        begin
            sum = OUT_W'(SUM_MAX);
        end
        else if (sum_ext < SUM_MIN)
        begin
            sum = OUT_W'(SUM_MIN);
        end
        else
        begin
            sum = OUT_W'(sum_ext);
        end
    end

endmodule

>>> hdl/imu_offset_cal_moving_average_core.sv
// each accepted input beat is registered in every lane stage on its way to the output
// throughput: one beat per cycle when not stalled; six axis lanes run in parallel,
// each a three-stage pipe (accumulate, offset divide, correct and window update)
// the window sum is kept as a running sum, so the ring depth does not set the rate
// reset: asynchronous active low; rings, sums, offsets and calibration state clear
// at once, gravity_counts returns to 4096 and offsets_locked to 0
module imu_offset_cal_moving_average_core
    import imuoc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_W-1:0]   acc_x,
    input  logic signed [SAMPLE_W-1:0]   acc_y,
    input  logic signed [SAMPLE_W-1:0]   acc_z,
    input  logic signed [SAMPLE_W-1:0]   gyro_x,
    input  logic signed [SAMPLE_W-1:0]   gyro_y,
    input  logic signed [SAMPLE_W-1:0]   gyro_z,
    input  logic                         start_acc_cal,
    input  logic                         start_gyro_cal,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [OUT_W-1:0]      acc_x_sum,
    output logic signed [OUT_W-1:0]      acc_y_sum,
    output logic signed [OUT_W-1:0]      acc_z_sum,
    output logic signed [OUT_W-1:0]      gyro_x_sum,
    output logic signed [OUT_W-1:0]      gyro_y_sum,
    output logic signed [OUT_W-1:0]      gyro_z_sum,
    output logic                         acc_cal_busy,
    output logic                         gyro_cal_busy
);

    logic [GRAV_W-1:0] gravity_reg;
    logic              locked_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic load1, load2, load3;
    logic [1:0] busy1_reg, busy2_reg, busy3_reg;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;

    cal_ctrl_t ctrl;

    logic signed [SAMPLE_W-1:0] samples [AXES];
    logic signed [OUT_W-1:0]    sums    [AXES];
    lane_cal_t                  lane_cal [AXES];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= GRAVITY_RESET;
            locked_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRAVITY_COUNTS: gravity_reg <= cfg_data[GRAV_W-1:0];
                REG_OFFSETS_LOCKED: locked_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // stall chain: a stage moves when the one after it has room
    assign rdy3     = ~v3_reg | out_ready;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign in_ready = rdy1;
    assign load1    = in_valid & rdy1;
    assign load2    = v1_reg & rdy2;
    assign load3    = v2_reg & rdy3;
    assign wp_next  = (wp_reg == PTR_W'(WINDOW - 1)) ? '0 : wp_reg + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            busy1_reg <= '0;
            busy2_reg <= '0;
            busy3_reg <= '0;
            wp_reg    <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (load1)
            begin
                busy1_reg <= {ctrl.gyro_busy, ctrl.acc_busy};
            end
            if (load2)
            begin
                busy2_reg <= busy1_reg;
            end
            if (load3)
            begin
                busy3_reg <= busy2_reg;
                wp_reg    <= wp_next;
            end
        end
    end

    imuoc_cal_ctrl u_cal_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (load1),
        .start_acc  (start_acc_cal),
        .start_gyro (start_gyro_cal),
        .ctrl       (ctrl)
    );

    assign samples[0] = acc_x;
    assign samples[1] = acc_y;
    assign samples[2] = acc_z;
    assign samples[3] = gyro_x;
    assign samples[4] = gyro_y;
    assign samples[5] = gyro_z;

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        assign lane_cal[a].en   = (a < 3) ? ctrl.acc_en : ctrl.gyro_en;
        assign lane_cal[a].done = (a < 3) ? ctrl.acc_done : ctrl.gyro_done;

        imuoc_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .load1  (load1),
            .load2  (load2),
            .load3  (load3),
            .sample (samples[a]),
            .cal    (lane_cal[a]),
            .bias   ((a == AXIS_ACC_Z) ? gravity_reg : '0),
            .locked (locked_reg),
            .wp     (wp_reg),
            .sum    (sums[a])
        );
    end

    // merge lane results into the output beat
    assign out_valid     = v3_reg;
    assign acc_x_sum     = sums[0];
    assign acc_y_sum     = sums[1];
    assign acc_z_sum     = sums[2];
    assign gyro_x_sum    = sums[3];
    assign gyro_y_sum    = sums[4];
    assign gyro_z_sum    = sums[5];
    assign acc_cal_busy  = busy3_reg[0];
    assign gyro_cal_busy = busy3_reg[1];

`ifndef SYNTHESIS
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output side is ready");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a bubble in the pipe");

    a_wp_moves_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !load3 |=> wp_reg == $past(wp_reg))
        else $error("window pointer moved without a beat");
`endif

endmodule

>>> sim/testbench.sv
// self-checking testbench for the imu offset calibration moving average core
`timescale 1ns / 1ps

module testbench;
    import imuoc_pkg::*;

    localparam int LATENCY     = 3;
    localparam int PHASES      = 7;
    localparam int PHASE_BEATS = 155;
    localparam int IDLE_LIMIT  = 2000;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic                             start_gyro;
        logic                             start_acc;
        logic [AXES-1:0][SAMPLE_W-1:0]    axis;
    } imu_beat_t;

    typedef struct packed {
        logic                             gyro_busy;
        logic                             acc_busy;
        logic [AXES-1:0][OUT_W-1:0]       sum;
    } sum_beat_t;

    class offset_window_tracker;
        int        ring[AXES][WINDOW];
        int        wr_ptr;
        longint    offset[AXES];
        longint    accum[AXES];
        int        acc_count;
        int        gyro_count;
        bit        acc_on;
        bit        gyro_on;
        longint    gravity;
        bit        locked;
        sum_beat_t due_sums[$];
        int        beats_checked;
        int        errors;
        string     field_label[AXES];

        function new();
            foreach (ring[a, k])
                ring[a][k] = 0;
            foreach (offset[a])
            begin
                offset[a] = 0;
                accum[a]  = 0;
            end
            wr_ptr        = 0;
            acc_count     = 0;
            gyro_count    = 0;
            acc_on        = 1'b0;
            gyro_on       = 1'b0;
            gravity       = GRAVITY_RESET;
            locked        = 1'b0;
            beats_checked = 0;
            errors        = 0;
            field_label   = '{"acc_x_sum", "acc_y_sum", "acc_z_sum",
                              "gyro_x_sum", "gyro_y_sum", "gyro_z_sum"};
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GRAVITY_COUNTS: gravity = data;
                REG_OFFSETS_LOCKED: locked  = data[0];
                default: ;
            endcase
        endfunction

        // end of a calibration run over three axes
        function void learn(int first_axis);
            int a;
            for (a = first_axis; a < first_axis + 3; a++)
            begin
                if (!locked)
                    offset[a] = clip(accum[a] / CAL_SAMPLES, -32768, 32767);
                accum[a] = 0;
            end
        endfunction

        function void take_sample(imu_beat_t s);
            sum_beat_t r;
            longint    v[AXES];
            longint    total;
            int        a;
            int        k;
            for (a = 0; a < AXES; a++)
                v[a] = longint'($signed(s.axis[a]));
            if (s.start_acc)
                acc_on = 1'b1;
            if (s.start_gyro)
                gyro_on = 1'b1;
            if (acc_on)
            begin
                acc_count++;
                accum[0] += v[0];
                accum[1] += v[1];
                accum[2] += v[2] - gravity;
                if (acc_count >= CAL_SAMPLES)
                begin
                    learn(0);
                    acc_count = 0;
                    acc_on    = 1'b0;
                end
            end
            if (gyro_on)
            begin
                gyro_count++;
                for (a = 3; a < AXES; a++)
                    accum[a] += v[a];
                if (gyro_count >= CAL_SAMPLES)
                begin
                    learn(3);
                    gyro_count = 0;
                    gyro_on    = 1'b0;
                end
            end
            // correction uses offsets learned on this very beat
            for (a = 0; a < AXES; a++)
            begin
                ring[a][wr_ptr] = int'(clip(v[a] - offset[a], -32768, 32767));
                total = 0;
                for (k = 0; k < WINDOW; k++)
                    total += ring[a][k];
                total = clip(total, -262144, 262143);
                r.sum[a] = total[OUT_W-1:0];
            end
            wr_ptr     = (wr_ptr + 1) % WINDOW;
            r.acc_busy  = acc_on;
            r.gyro_busy = gyro_on;
            due_sums.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: output beat %0d: %s", $time, beats_checked, msg);
        endfunction

        function void match_sums(sum_beat_t got);
            sum_beat_t want;
            int        a;
            beats_checked++;
            if (due_sums.size() == 0)
            begin
                report("output beat with no sums pending");
                return;
            end
            want = due_sums.pop_front();
            for (a = 0; a < AXES; a++)
                if (got.sum[a] !== want.sum[a])
                    report($sformatf("%s expected %0d, got %0d", field_label[a],
                                     $signed(want.sum[a]), $signed(got.sum[a])));
            if (got.acc_busy !== want.acc_busy)
                report($sformatf("acc_cal_busy expected %0d, got %0d",
                                 want.acc_busy, got.acc_busy));
            if (got.gyro_busy !== want.gyro_busy)
                report($sformatf("gyro_cal_busy expected %0d, got %0d",
                                 want.gyro_busy, got.gyro_busy));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] acc_x;
    logic signed [SAMPLE_W-1:0] acc_y;
    logic signed [SAMPLE_W-1:0] acc_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic                       start_acc_cal;
    logic                       start_gyro_cal;

    logic                       out_valid;
    logic                       out_ready;
    logic signed [OUT_W-1:0]    acc_x_sum;
    logic signed [OUT_W-1:0]    acc_y_sum;
    logic signed [OUT_W-1:0]    acc_z_sum;
    logic signed [OUT_W-1:0]    gyro_x_sum;
    logic signed [OUT_W-1:0]    gyro_y_sum;
    logic signed [OUT_W-1:0]    gyro_z_sum;
    logic                       acc_cal_busy;
    logic                       gyro_cal_busy;

    imu_beat_t            drv;
    int                   idle_cycles = 0;
    offset_window_tracker tracker;

    assign acc_x          = drv.axis[0];
    assign acc_y          = drv.axis[1];
    assign acc_z          = drv.axis[2];
    assign gyro_x         = drv.axis[3];
    assign gyro_y         = drv.axis[4];
    assign gyro_z         = drv.axis[5];
    assign start_acc_cal  = drv.start_acc;
    assign start_gyro_cal = drv.start_gyro;

    imu_offset_cal_moving_average_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .acc_x          (acc_x),
        .acc_y          (acc_y),
        .acc_z          (acc_z),
        .gyro_x         (gyro_x),
        .gyro_y         (gyro_y),
        .gyro_z         (gyro_z),
        .start_acc_cal  (start_acc_cal),
        .start_gyro_cal (start_gyro_cal),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .acc_x_sum      (acc_x_sum),
        .acc_y_sum      (acc_y_sum),
        .acc_z_sum      (acc_z_sum),
        .gyro_x_sum     (gyro_x_sum),
        .gyro_y_sum     (gyro_y_sum),
        .gyro_z_sum     (gyro_z_sum),
        .acc_cal_busy   (acc_cal_busy),
        .gyro_cal_busy  (gyro_cal_busy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : watch_ports
        sum_beat_t got;
        if (in_valid && in_ready)
            tracker.take_sample(drv);
        if (out_valid && out_ready)
        begin
            got.sum[0]    = acc_x_sum;
            got.sum[1]    = acc_y_sum;
            got.sum[2]    = acc_z_sum;
            got.sum[3]    = gyro_x_sum;
            got.sum[4]    = gyro_y_sum;
            got.sum[5]    = gyro_z_sum;
            got.acc_busy  = acc_cal_busy;
            got.gyro_busy = gyro_cal_busy;
            tracker.match_sums(got);
        end
        idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                       0 : idle_cycles + 1;
    end

    // output stalls: mostly short, a few long, plus long always-ready stretches
    initial
    begin : drive_out_ready
        int r;
        int len;
        bit level;
        out_ready = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                level = 1'b1;
                len   = $urandom_range(40, 160);
            end
            else if (r < 55)
            begin
                level = 1'b1;
                len   = $urandom_range(1, 6);
            end
            else if (r < 95)
            begin
                level = 1'b0;
                len   = $urandom_range(1, 4);
            end
            else
            begin
                level = 1'b0;
                len   = $urandom_range(15, 60);
            end
            @(negedge clk);
            out_ready <= level;
            repeat (len - 1) @(negedge clk);
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("FAIL");
        $finish;
    end

    function automatic imu_beat_t uniform_beat(logic [SAMPLE_W-1:0] v, bit sa, bit sg);
        imu_beat_t s;
        int        a;
        for (a = 0; a < AXES; a++)
            s.axis[a] = v;
        s.start_acc  = sa;
        s.start_gyro = sg;
        return s;
    endfunction

    // extremes, full-range noise, or a value scattered around a per-axis bias
    function automatic logic [SAMPLE_W-1:0] draw_axis(longint center, int spread);
        int     r;
        longint v;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 30)
            return SAMPLE_W'($urandom_range(0, 65535));
        v = center + longint'($urandom_range(0, 2 * spread)) - spread;
        v = offset_window_tracker::clip(v, -32768, 32767);
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_beat(imu_beat_t s, bit steady);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = (steady || r < 55) ? 0 :
              (r < 85) ? $urandom_range(1, 3) :
              (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        drv      <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop feeding and let the pipe empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.due_sums.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic configure(int p);
        case (p)
            1:
            begin
                write_reg(REG_GRAVITY_COUNTS, 15'd0);
                write_reg(REG_OFFSETS_LOCKED, 15'd0);
            end
            2:  write_reg(REG_GRAVITY_COUNTS, 15'h7FFF);
            3:
            begin
                write_reg(REG_GRAVITY_COUNTS, CFG_DATA_W'($urandom_range(0, 32767)));
                write_reg(REG_OFFSETS_LOCKED, 15'd1);
            end
            4:
            begin
                write_reg(REG_SPARE_HI, 15'h0001);
                write_reg(REG_OFFSETS_LOCKED, 15'h7FFE);
                write_reg(REG_GRAVITY_COUNTS, CFG_DATA_W'($urandom_range(0, 32767)));
            end
            5:
            begin
                write_reg(REG_OFFSETS_LOCKED, 15'h7FFF);
                write_reg(REG_GRAVITY_COUNTS, 15'd16384);
                write_reg(REG_SPARE_LO, 15'd0);
            end
            default:
            begin
                write_reg(REG_OFFSETS_LOCKED, 15'd0);
                write_reg(REG_GRAVITY_COUNTS, 15'd4096);
            end
        endcase
    endtask

    initial
    begin : main_flow
        imu_beat_t s;
        longint    bias[AXES];
        int        spread[AXES];
        int        i;
        int        a;
        int        p;
        int        r;
        int        gyro_kick;
        bit        steady;
        bit        opening;

        tracker   = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        drv       = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: bit patterns, full-scale windows, calibration starts
        send_beat(uniform_beat(16'h0000, 1'b0, 1'b0), 1'b0);
        send_beat(uniform_beat(16'h5555, 1'b0, 1'b0), 1'b0);
        send_beat(uniform_beat(16'hAAAA, 1'b0, 1'b0), 1'b0);
        for (i = 0; i < WINDOW; i++)
            send_beat(uniform_beat(16'h7FFF, 1'b0, 1'b0), 1'b0);
        for (i = 0; i < WINDOW; i++)
            send_beat(uniform_beat(16'h8000, 1'b0, 1'b0), 1'b0);
        send_beat(uniform_beat(16'hFFFF, 1'b1, 1'b0), 1'b0);
        send_beat(uniform_beat(16'h0001, 1'b0, 1'b1), 1'b0);
        // both already busy, so these requests must not restart anything
        send_beat(uniform_beat(16'h0000, 1'b1, 1'b1), 1'b0);

        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                configure(p);
            end
            for (a = 0; a < AXES; a++)
            begin
                r       = $urandom_range(0, 99);
                bias[a] = (r < 15) ? -32768 : (r < 30) ? 32767 : (r < 50) ? 0 :
                          longint'($urandom_range(0, 65535)) - 32768;
                case ($urandom_range(0, 3))
                    0:       spread[a] = 0;
                    1:       spread[a] = 7;
                    2:       spread[a] = 200;
                    default: spread[a] = 3000;
                endcase
            end
            // with full gravity removed this drives the z offset into saturation
            if (p == 2)
            begin
                bias[2]   = -32768;
                spread[2] = 0;
            end
            steady    = (p % 3 == 1);
            gyro_kick = $urandom_range(0, 20);
            for (i = 0; i < PHASE_BEATS; i++)
            begin
                for (a = 0; a < AXES; a++)
                    s.axis[a] = draw_axis(bias[a], spread[a]);
                // no new starts near the end, so every run finishes in this phase
                opening      = (i < PHASE_BEATS - CAL_SAMPLES);
                s.start_acc  = opening && (i == 0 || $urandom_range(0, 24) == 0);
                s.start_gyro = opening && (i == gyro_kick || $urandom_range(0, 24) == 0);
                send_beat(s, steady);
            end
        end

        settle();
        repeat (LATENCY + 5) @(negedge clk);
        if (tracker.errors == 0 && tracker.due_sums.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> imu_offset_cal_moving_average_core.f
hdl/imuoc_pkg.sv
hdl/imuoc_cal_ctrl.sv
hdl/imuoc_lane.sv
hdl/imu_offset_cal_moving_average_core.sv
sim/testbench.sv
